// ===== sv/gia2q_pkg.sv =====
// ============================================================================
// gia2q_pkg: shared types and constants for the angle to q unit
// Holds fixed-point constants, the CORDIC arctangent table and the
// bundle that travels along the chain of rotation cells.
// ============================================================================
`default_nettype none

package gia2q_pkg;

    // Number of rotation cells in the chain
    localparam int CORDIC_STAGES = 24;
    localparam int STAGE_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
    localparam int NUM_ANGLES = 3;

    // Lane positions within a bundle
    localparam int ANGLE_AI  = 0;
    localparam int ANGLE_AF  = 1;
    localparam int ANGLE_TTH = 2;

    // Register indexes
    localparam logic REG_WAVE_NUMBER = 1'b0;
    localparam logic REG_ANGLE_UNIT  = 1'b1;

    // Fixed-point constants
    localparam logic [30:0]        DEG_TO_TURN       = 31'd11930465;
    localparam logic [30:0]        RAD_TO_TURN       = 31'd683565276;
    localparam logic signed [31:0] HALF_PI_Q30       = 32'sd1686629713;
    localparam logic signed [32:0] CORDIC_INV_GAIN   = 33'sd652032874;
    localparam logic signed [32:0] ONE_Q30           = 33'sd1073741824;
    localparam logic [31:0]        WAVE_NUMBER_RESET = 32'd68424198;

    // One angle in flight through the rotation chain
    typedef struct packed {
        logic [32:0] x;
        logic [32:0] y;
        logic [31:0] z;
        logic [1:0]  quad;
    } lane_t;

    // Everything one cell hands to the next
    typedef struct packed {
        logic                         valid;
        logic                         last;
        lane_t [NUM_ANGLES-1:0]       lane;
    } cell_t;

    // Arctangent of 2^-i in Q2.30
    function automatic logic signed [31:0] atan_entry(input logic [STAGE_W-1:0] i);
        logic [31:0] v;
        case (int'(i))
            0:       v = 32'h3243F6A8;
            1:       v = 32'h1DAC6705;
            2:       v = 32'h0FADBAFC;
            3:       v = 32'h07F56EA6;
            4:       v = 32'h03FEAB76;
            5:       v = 32'h01FFD55B;
            6:       v = 32'h00FFFAAA;
            7:       v = 32'h007FFF55;
            8:       v = 32'h003FFFEA;
            9:       v = 32'h001FFFFD;
            default: v = (int'(i) <= 30) ? (32'd1 << (30 - int'(i))) : 32'd0;
        endcase
        return $signed(v);
    endfunction

endpackage

`default_nettype wire

// ===== sv/gia2q_prep.sv =====
// ============================================================================
// gia2q_prep: angle to reduced CORDIC argument
// Scales a Q9.22 angle to a binary turn, splits off the quadrant and
// converts the residual to radians in Q2.30. Four register stages.
// ============================================================================
`default_nettype none

module gia2q_prep (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] angle,
    input  wire logic        degrees,
    output logic [31:0]      z,
    output logic [1:0]       quad
);

    logic [30:0]        turn_scale;
    logic signed [62:0] prod_full;
    logic [53:0]        prod_reg;
    logic [53:0]        round_sum;
    logic [31:0]        turns;
    logic [31:0]        r_val;
    logic signed [30:0] res_next;
    logic signed [30:0] res_reg;
    logic [1:0]         quad_s2_reg;
    logic signed [62:0] mult_reg;
    logic [1:0]         quad_s3_reg;
    logic signed [62:0] z_sum;
    logic [31:0]        z_reg;
    logic [1:0]         quad_reg;

    // Stage 1: angle times turns per unit
    assign turn_scale = degrees ? gia2q_pkg::DEG_TO_TURN : gia2q_pkg::RAD_TO_TURN;
    assign prod_full  = $signed(angle) * $signed({1'b0, turn_scale});

    // Stage 2: round to a 32-bit turn, split quadrant and residual
    assign round_sum = prod_reg + 54'd2097152;
    assign turns     = round_sum[53:22];
    assign r_val     = turns + 32'h2000_0000;
    assign res_next  = $signed({1'b0, r_val[29:0]}) - 31'sd536870912;

    // Stage 4: round residual radians back to Q2.30
    assign z_sum = mult_reg + 63'sd536870912;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg    <= prod_full[53:0];
            res_reg     <= res_next;
            quad_s2_reg <= r_val[31:30];
            mult_reg    <= res_reg * gia2q_pkg::HALF_PI_Q30;
            quad_s3_reg <= quad_s2_reg;
            z_reg       <= z_sum[61:30];
            quad_reg    <= quad_s3_reg;
        end
    end

    assign z    = z_reg;
    assign quad = quad_reg;

endmodule

`default_nettype wire

// ===== sv/gia2q_cordic_cell.sv =====
// ============================================================================
// gia2q_cordic_cell: one CORDIC rotation step
// Rotates all three lanes by plus or minus atan(2^-stage) and passes the
// bundle to the next cell.
// ============================================================================
`default_nettype none

module gia2q_cordic_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic [gia2q_pkg::STAGE_W-1:0] stage,
    input  wire gia2q_pkg::cell_t              cell_in,
    output gia2q_pkg::cell_t                   cell_out
);

    logic signed [31:0] atan_val;
    gia2q_pkg::lane_t [gia2q_pkg::NUM_ANGLES-1:0] lane_next;
    gia2q_pkg::lane_t [gia2q_pkg::NUM_ANGLES-1:0] lane_reg;
    logic valid_reg;
    logic last_reg;

    assign atan_val = gia2q_pkg::atan_entry(stage);

    // Rotation per lane
    always_comb
    begin
        for (int a = 0; a < gia2q_pkg::NUM_ANGLES; a++)
        begin
            logic signed [32:0] dx;
            logic signed [32:0] dy;
            dx = $signed(cell_in.lane[a].y) >>> stage;
            dy = $signed(cell_in.lane[a].x) >>> stage;
            lane_next[a].quad = cell_in.lane[a].quad;
            if (!cell_in.lane[a].z[31])
            begin
                lane_next[a].x = $signed(cell_in.lane[a].x) - dx;
                lane_next[a].y = $signed(cell_in.lane[a].y) + dy;
                lane_next[a].z = $signed(cell_in.lane[a].z) - atan_val;
            end
            else
            begin
                lane_next[a].x = $signed(cell_in.lane[a].x) + dx;
                lane_next[a].y = $signed(cell_in.lane[a].y) - dy;
                lane_next[a].z = $signed(cell_in.lane[a].z) + atan_val;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= cell_in.valid;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
            last_reg <= cell_in.last;
        end
    end

    assign cell_out.valid = valid_reg;
    assign cell_out.last  = last_reg;
    assign cell_out.lane  = lane_reg;

endmodule

`default_nettype wire

// ===== sv/gia2q_qcalc.sv =====
// ============================================================================
// gia2q_qcalc: sine/cosine to momentum transfer
// Quadrant fix and clamp, angle products, scaling by the wave number and
// saturation to Q7.24. Four register stages, saturation after the last.
// ============================================================================
`default_nettype none

module gia2q_qcalc (
    input  wire logic                                         clk,
    input  wire logic                                         en,
    input  wire gia2q_pkg::lane_t [gia2q_pkg::NUM_ANGLES-1:0] lane,
    input  wire logic [31:0]                                  wave_number,
    output logic [31:0]                                       q_x,
    output logic [31:0]                                       q_y,
    output logic [31:0]                                       q_z
);

    logic signed [31:0] cos_next [gia2q_pkg::NUM_ANGLES];
    logic signed [31:0] sin_next [gia2q_pkg::NUM_ANGLES];
    logic signed [31:0] cos_reg  [gia2q_pkg::NUM_ANGLES];
    logic signed [31:0] sin_reg  [gia2q_pkg::NUM_ANGLES];
    logic signed [63:0] prod_cc_reg;
    logic signed [63:0] prod_cs_reg;
    logic signed [31:0] cos_ai_reg;
    logic signed [32:0] sum_z_reg;
    logic signed [63:0] rnd_cc;
    logic signed [63:0] rnd_cs;
    logic signed [32:0] v_next [3];
    logic signed [32:0] v_reg  [3];
    logic signed [65:0] kp_reg [3];
    logic [31:0]        q_sat  [3];

    function automatic logic signed [31:0] clamp_unit(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > gia2q_pkg::ONE_Q30)
            r = 32'sd1073741824;
        else if (v < -gia2q_pkg::ONE_Q30)
            r = -32'sd1073741824;
        else
            r = v[31:0];
        return r;
    endfunction

    // Quadrant fix and clamp
    always_comb
    begin
        for (int a = 0; a < gia2q_pkg::NUM_ANGLES; a++)
        begin
            logic signed [32:0] xv;
            logic signed [32:0] yv;
            logic signed [32:0] c2;
            logic signed [32:0] s2;
            xv = $signed(lane[a].x);
            yv = $signed(lane[a].y);
            case (lane[a].quad)
                2'd0:    begin c2 = xv;  s2 = yv;  end
                2'd1:    begin c2 = -yv; s2 = xv;  end
                2'd2:    begin c2 = -xv; s2 = -yv; end
                default: begin c2 = yv;  s2 = -xv; end
            endcase
            cos_next[a] = clamp_unit(c2);
            sin_next[a] = clamp_unit(s2);
        end
    end

    // Round the angle products back to Q2.30 and form the three components
    assign rnd_cc = (prod_cc_reg + 64'sd536870912) >>> 30;
    assign rnd_cs = (prod_cs_reg + 64'sd536870912) >>> 30;

    always_comb
    begin
        v_next[0] = 33'(cos_ai_reg) - rnd_cc[32:0];
        v_next[1] = rnd_cs[32:0];
        v_next[2] = sum_z_reg;
    end

    // Round Q8.54 to Q7.24 and saturate
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic signed [65:0] rs;
            rs = (kp_reg[c] + 66'sd536870912) >>> 30;
            if (rs > 66'sd2147483647)
                q_sat[c] = 32'h7FFF_FFFF;
            else if (rs < -66'sd2147483648)
                q_sat[c] = 32'h8000_0000;
            else
                q_sat[c] = rs[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < gia2q_pkg::NUM_ANGLES; a++)
            begin
                cos_reg[a] <= cos_next[a];
                sin_reg[a] <= sin_next[a];
            end
            prod_cc_reg <= cos_reg[gia2q_pkg::ANGLE_AF] * cos_reg[gia2q_pkg::ANGLE_TTH];
            prod_cs_reg <= cos_reg[gia2q_pkg::ANGLE_AF] * sin_reg[gia2q_pkg::ANGLE_TTH];
            cos_ai_reg  <= cos_reg[gia2q_pkg::ANGLE_AI];
            sum_z_reg   <= 33'(sin_reg[gia2q_pkg::ANGLE_AI])
                         + 33'(sin_reg[gia2q_pkg::ANGLE_AF]);
            for (int c = 0; c < 3; c++)
            begin
                v_reg[c]  <= v_next[c];
                kp_reg[c] <= $signed({1'b0, wave_number}) * v_reg[c];
            end
        end
    end

    assign q_x = q_sat[0];
    assign q_y = q_sat[1];
    assign q_z = q_sat[2];

endmodule

`default_nettype wire

// ===== sv/grazing_incidence_angle_to_q_unit.sv =====
// ============================================================================
// grazing_incidence_angle_to_q_unit: diffraction angles to momentum transfer
// Three angles per request pass through a row of CORDIC cells and come
// out as saturated qx, qy, qz in Q7.24.
// ============================================================================
//
//  Channel   Handshake               Payload
//  -------   ---------------------   ------------------------------------------
//  in        in_valid / in_ready     incidence/exit/inplane angle, last_point
//  out       out_valid / out_ready   q_x, q_y, q_z, last_result
//  config    cfg_we                  cfg_index, cfg_data
//
//  One request per cycle sustained while the output is taken. The path has
//  4 prep stages, one cell per stage, 4 product stages, output register.
//  The whole pipeline advances when the output register is empty or taken;
//  a stalled output holds every stage. Reset clears valid flags only and
//  loads the register reset values.
//
`default_nettype none

module grazing_incidence_angle_to_q_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] incidence_angle,
    input  wire logic [31:0] exit_angle,
    input  wire logic [31:0] inplane_angle,
    input  wire logic        last_point,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      q_x,
    output logic [31:0]      q_y,
    output logic [31:0]      q_z,
    output logic             last_result,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int PREP_DEPTH = 4;
    localparam int POST_DEPTH = 4;

    logic        en;
    logic [31:0] wave_number_reg;
    logic        degrees_reg;
    logic [PREP_DEPTH-1:0] pv_reg;
    logic [PREP_DEPTH-1:0] pl_reg;
    logic [POST_DEPTH-1:0] qv_reg;
    logic [POST_DEPTH-1:0] ql_reg;
    logic        out_valid_reg;
    logic        out_last_reg;
    logic [31:0] qx_reg;
    logic [31:0] qy_reg;
    logic [31:0] qz_reg;
    logic [31:0] qx_next;
    logic [31:0] qy_next;
    logic [31:0] qz_next;
    logic [31:0] angle_in [gia2q_pkg::NUM_ANGLES];
    logic [31:0] z_prep   [gia2q_pkg::NUM_ANGLES];
    logic [1:0]  quad_prep [gia2q_pkg::NUM_ANGLES];
    gia2q_pkg::cell_t chain [gia2q_pkg::CORDIC_STAGES+1];

    // Pipeline advance
    assign en       = out_ready | ~out_valid_reg;
    assign in_ready = en;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_number_reg <= gia2q_pkg::WAVE_NUMBER_RESET;
            degrees_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gia2q_pkg::REG_WAVE_NUMBER: wave_number_reg <= cfg_data;
                gia2q_pkg::REG_ANGLE_UNIT:  degrees_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Angle preparation
    assign angle_in[gia2q_pkg::ANGLE_AI]  = incidence_angle;
    assign angle_in[gia2q_pkg::ANGLE_AF]  = exit_angle;
    assign angle_in[gia2q_pkg::ANGLE_TTH] = inplane_angle;

    for (genvar a = 0; a < gia2q_pkg::NUM_ANGLES; a++)
    begin : g_prep
        gia2q_prep u_prep (
            .clk     (clk),
            .en      (en),
            .angle   (angle_in[a]),
            .degrees (degrees_reg),
            .z       (z_prep[a]),
            .quad    (quad_prep[a])
        );
    end

    // Head of the cell chain
    always_comb
    begin
        chain[0].valid = pv_reg[PREP_DEPTH-1];
        chain[0].last  = pl_reg[PREP_DEPTH-1];
        for (int a = 0; a < gia2q_pkg::NUM_ANGLES; a++)
        begin
            chain[0].lane[a].x    = gia2q_pkg::CORDIC_INV_GAIN;
            chain[0].lane[a].y    = 33'd0;
            chain[0].lane[a].z    = z_prep[a];
            chain[0].lane[a].quad = quad_prep[a];
        end
    end

    // Row of rotation cells
    for (genvar i = 0; i < gia2q_pkg::CORDIC_STAGES; i++)
    begin : g_cell
        gia2q_cordic_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .stage    (gia2q_pkg::STAGE_W'(i)),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    // Products, scaling and saturation
    gia2q_qcalc u_qcalc (
        .clk         (clk),
        .en          (en),
        .lane        (chain[gia2q_pkg::CORDIC_STAGES].lane),
        .wave_number (wave_number_reg),
        .q_x         (qx_next),
        .q_y         (qy_next),
        .q_z         (qz_next)
    );

    // Valid flags along prep and product stages, output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg        <= '0;
            qv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pv_reg        <= {pv_reg[PREP_DEPTH-2:0], in_valid};
            qv_reg        <= {qv_reg[POST_DEPTH-2:0], chain[gia2q_pkg::CORDIC_STAGES].valid};
            out_valid_reg <= qv_reg[POST_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl_reg       <= {pl_reg[PREP_DEPTH-2:0], last_point};
            ql_reg       <= {ql_reg[POST_DEPTH-2:0], chain[gia2q_pkg::CORDIC_STAGES].last};
            out_last_reg <= ql_reg[POST_DEPTH-1];
            qx_reg       <= qx_next;
            qy_reg       <= qy_next;
            qz_reg       <= qz_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign last_result = out_last_reg;
    assign q_x         = qx_reg;
    assign q_y         = qy_reg;
    assign q_z         = qz_reg;

endmodule

`default_nettype wire

// ===== sv/gia2q_checker.sv =====
// ============================================================================
// gia2q_checker: port-level checks for the angle to q unit
// Watches the handshakes on the top level and is bound to it.
// ============================================================================
`default_nettype none

module gia2q_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] q_x,
    input wire logic [31:0] q_y,
    input wire logic [31:0] q_z,
    input wire logic        last_result
);

    // An empty output register never blocks a request
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with empty output");

    // A stalled output stalls the whole pipeline
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("request taken while output stalled");

    // A pending result stays up
    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped before taken");

    // A pending result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(q_x) && $stable(q_y) && $stable(q_z)
                                       && $stable(last_result)))
        else $error("result changed while stalled");

endmodule

bind grazing_incidence_angle_to_q_unit gia2q_checker u_gia2q_checker (.*);

`default_nettype wire

// ===== test/tb_top.sv =====
// ============================================================================
// tb_top: testbench for grazing_incidence_angle_to_q_unit
// Sends angle triples through the valid/ready input, predicts qx, qy, qz
// with a fixed-point model of its own and checks every returned request in
// order. Covers both angle units and several wave numbers, with random stalls.
// ============================================================================
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

    localparam int LATENCY = gia2q_pkg::CORDIC_STAGES + 9;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic [31:0] qx;
        logic [31:0] qy;
        logic [31:0] qz;
        logic        last;
    } q_point_t;

    // Directed rows: angles, last flag, known flag, known result
    typedef struct {
        logic [31:0] ai;
        logic [31:0] af;
        logic [31:0] tth;
        logic        last;
        logic        known;
        q_point_t    q;
    } angle_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] incidence_angle = '0;
    logic [31:0] exit_angle = '0;
    logic [31:0] inplane_angle = '0;
    logic        last_point = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] q_x;
    logic [31:0] q_y;
    logic [31:0] q_z;
    logic        last_result;
    logic        cfg_we = 1'b0;
    logic        cfg_index = gia2q_pkg::REG_WAVE_NUMBER;
    logic [31:0] cfg_data = '0;

    // Predictor copy of the registers
    logic [31:0] k_reg;
    logic        deg_reg;

    q_point_t    q_expected[$];
    int          mismatches = 0;
    int          cycles = 0;
    int          stall_left = 0;
    bit          quiet = 1'b0;
    bit          in_done = 1'b0;

    logic [31:0] k_set [5] = '{32'd68424198, 32'hFFFFFFFF, 32'd0, 32'd1 << 24,
                               32'h7F000000};

    grazing_incidence_angle_to_q_unit DUT (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // floor((v + round) / 2^s)
    function automatic longint shift_round(longint v, int s, bit rnd);
        if (s == 0)
            return v;
        if (rnd)
            v = v + (64'sd1 <<< (s - 1));
        return v >>> s;
    endfunction

    function automatic longint clamp_one(longint v);
        if (v > 64'sd1073741824)
            return 64'sd1073741824;
        if (v < -64'sd1073741824)
            return -64'sd1073741824;
        return v;
    endfunction

    function automatic longint arctan_q30(int i);
        case (i)
            0: return 64'h3243F6A8;
            1: return 64'h1DAC6705;
            2: return 64'h0FADBAFC;
            3: return 64'h07F56EA6;
            4: return 64'h03FEAB76;
            5: return 64'h01FFD55B;
            6: return 64'h00FFFAAA;
            7: return 64'h007FFF55;
            8: return 64'h003FFFEA;
            9: return 64'h001FFFFD;
            default: return (i <= 30) ? (64'sd1 <<< (30 - i)) : 64'sd0;
        endcase
    endfunction

    // Sine and cosine in Q2.30 of an angle in Q9.22
    task automatic rotate_angle(input logic [31:0] raw, output longint sn, output longint cs);
        longint      prod;
        logic [31:0] turns;
        logic [31:0] r;
        logic [1:0]  quad;
        longint      res;
        longint      z;
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        longint      c2;
        longint      s2;
        prod = longint'($signed(raw)) * (deg_reg ? 64'sd11930465 : 64'sd683565276);
        turns = 32'((prod + 64'sd2097152) >>> 22);
        r = turns + 32'h20000000;
        quad = r[31:30];
        res = longint'({2'b00, r[29:0]}) - 64'sd536870912;
        z = shift_round(res * 64'sd1686629713, 30, 1'b1);
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < gia2q_pkg::CORDIC_STAGES; i++)
        begin
            dx = shift_round(y, i, 1'b0);
            dy = shift_round(x, i, 1'b0);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= arctan_q30(i);
            end
            else
            begin
                x += dx; y -= dy; z += arctan_q30(i);
            end
        end
        case (quad)
            2'd0: begin c2 = x;  s2 = y;  end
            2'd1: begin c2 = -y; s2 = x;  end
            2'd2: begin c2 = -x; s2 = -y; end
            default: begin c2 = y; s2 = -x; end
        endcase
        cs = clamp_one(c2);
        sn = clamp_one(s2);
    endtask

    function automatic logic [31:0] scale_by_k(longint v);
        longint p;
        p = shift_round(longint'({32'd0, k_reg}) * v, 30, 1'b1);
        if (p > 64'sd2147483647)
            p = 64'sd2147483647;
        if (p < -64'sd2147483648)
            p = -64'sd2147483648;
        return p[31:0];
    endfunction

    task automatic predict_q(input angle_row_t a, output q_point_t q);
        longint s_ai, c_ai, s_af, c_af, s_tt, c_tt;
        rotate_angle(a.ai, s_ai, c_ai);
        rotate_angle(a.af, s_af, c_af);
        rotate_angle(a.tth, s_tt, c_tt);
        q.qx = scale_by_k(c_ai - shift_round(c_af * c_tt, 30, 1'b1));
        q.qy = scale_by_k(shift_round(c_af * s_tt, 30, 1'b1));
        q.qz = scale_by_k(s_ai + s_af);
        q.last = a.last;
    endtask

    // Register write, block idle
    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == gia2q_pkg::REG_WAVE_NUMBER)
            k_reg = val;
        else
            deg_reg = val[0];
    endtask

    // Send one request, predicted result queued at acceptance
    task automatic send_point(input angle_row_t a);
        q_point_t q;
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        predict_q(a, q);
        if (a.known && q != a.q)
        begin
            $display("row table disagrees with predictor: %h vs %h", a.q, q);
            mismatches++;
        end
        in_valid <= 1'b1;
        incidence_angle <= a.ai;
        exit_angle <= a.af;
        inplane_angle <= a.tth;
        last_point <= a.last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        q_expected.push_back(q);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (q_expected.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_angle();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 360 << 22)) - (180 << 22));
            2: return 32'($signed($urandom_range(0, 26353589)) - 13176794);
            3: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF} ^ $urandom_range(0, 255);
            default: return 32'($urandom_range(0, 720)) << 21;
        endcase
    endfunction

    // Output side: random stall bursts on out_ready, checking
    always @(posedge clk)
    begin
        q_point_t got;
        q_point_t want;
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (quiet)
            begin
                stall_left = 0;
                out_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 7);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
            if (out_valid && out_ready)
            begin
                got = '{q_x, q_y, q_z, last_result};
                if (q_expected.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result %h", got);
                    mismatches++;
                end
                else
                begin
                    want = q_expected.pop_front();
                    if (got != want)
                    begin
                        if (mismatches < 10)
                            $display("q mismatch: exp x=%h y=%h z=%h l=%b got x=%h y=%h z=%h l=%b",
                                     want.qx, want.qy, want.qz, want.last,
                                     got.qx, got.qy, got.qz, got.last);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        if (cycles > LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    angle_row_t rows[] = '{
        '{32'h0, 32'h0, 32'h0, 1'b0, 1'b0, '0},
        '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 1'b0, '0},
        '{32'h80000000, 32'h80000000, 32'h80000000, 1'b0, 1'b0, '0},
        '{32'h80000000, 32'h7FFFFFFF, 32'h0, 1'b1, 1'b0, '0},
        '{32'd90 << 22, 32'd90 << 22, 32'd0, 1'b0, 1'b0, '0},
        '{32'd180 << 22, 32'd0, 32'd90 << 22, 1'b0, 1'b0, '0},
        '{-(32'd90 << 22), 32'd270 << 22, 32'd45 << 22, 1'b1, 1'b0, '0},
        '{32'd1 << 22, 32'd2 << 22, 32'd30 << 22, 1'b0, 1'b0, '0},
        '{32'hFFFFFFFF, 32'h1, 32'hFFFFFFFF, 1'b0, 1'b0, '0},
        '{32'd720 << 22, -(32'd360 << 22), 32'd400 << 22, 1'b1, 1'b0, '0}
    };

    initial
    begin
        angle_row_t a;
        k_reg = gia2q_pkg::WAVE_NUMBER_RESET;
        deg_reg = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table in both units with reset k; in degrees also large k (saturation) and zero k
        for (int u = 0; u < 2; u++)
        begin
            foreach (rows[i])
            begin
                a = rows[i];
                a.known = a.known && u == 0;
                send_point(a);
            end
            drain();
            if (u == 0)
            begin
                write_reg(gia2q_pkg::REG_WAVE_NUMBER, 32'hFFFFFFFF);
                foreach (rows[i])
                    send_point(rows[i]);
                drain();
                // Zero wave number gives zero q for any angle
                write_reg(gia2q_pkg::REG_WAVE_NUMBER, 32'd0);
                foreach (rows[i])
                begin
                    a = rows[i];
                    a.known = 1'b1;
                    a.q = '{32'h0, 32'h0, 32'h0, rows[i].last};
                    send_point(a);
                end
                drain();
                write_reg(gia2q_pkg::REG_WAVE_NUMBER, gia2q_pkg::WAVE_NUMBER_RESET);
                write_reg(gia2q_pkg::REG_ANGLE_UNIT, 32'h0);
            end
        end

        // Random phases across register settings
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(gia2q_pkg::REG_WAVE_NUMBER, (ph % 2) ? $urandom() : k_set[ph / 2]);
            write_reg(gia2q_pkg::REG_ANGLE_UNIT, $urandom());
            quiet = (ph == 9);
            for (int n = 0; n < 65; n++)
            begin
                a.ai = rand_angle();
                a.af = rand_angle();
                a.tth = rand_angle();
                a.last = $urandom_range(0, 1);
                a.known = 1'b0;
                send_point(a);
            end
            drain();
        end

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
